// ===== sv/kls_pkg.sv =====
// Shared constants and types for the k-th largest selection block.
package kls_pkg;

  localparam int MAX_K   = 64;
  localparam int VAL_W   = 32;
  localparam int K_W     = 7;
  localparam int CNT_W   = $clog2(MAX_K + 1);
  localparam int IDX_W   = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int CMP_W   = (K_W > CNT_W) ? K_W : CNT_W;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  localparam logic REG_K_RANK = 1'b0;
  localparam logic [K_W-1:0] K_RANK_RESET = K_W'(1);

  typedef enum logic {
    ST_LOAD,
    ST_EXTRACT
  } kls_state_e;

  typedef struct packed {
    logic insert;
    logic shift;
  } kls_chain_ctrl_t;

endpackage

// ===== sv/kls_cell.sv =====
// One compare-insert cell of the sorted chain.
module kls_cell import kls_pkg::*; (
  input  logic                    clk_i,
  input  kls_chain_ctrl_t         ctrl_i,
  input  logic                    occupied_i,
  input  logic signed [VAL_W-1:0] value_i,
  input  logic                    prev_gt_i,
  input  logic signed [VAL_W-1:0] prev_val_i,
  input  logic signed [VAL_W-1:0] next_val_i,
  output logic                    gt_o,
  output logic signed [VAL_W-1:0] val_o
);

  logic signed [VAL_W-1:0] val_q, val_d;

  // empty cells always compare as smaller and take a shifted or the incoming value; ties land behind equals
  assign gt_o  = !occupied_i || (value_i > val_q);
  assign val_o = val_q;

  always_comb begin
    val_d = val_q;
    if (ctrl_i.insert) begin
      if (gt_o) begin
        val_d = prev_gt_i ? prev_val_i : value_i;
      end
    end else if (ctrl_i.shift) begin
      val_d = next_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

// ===== sv/kls_chain.sv =====
// Row of compare-insert cells holding the largest values in descending order.
module kls_chain import kls_pkg::*; (
  input  logic                    clk_i,
  input  kls_chain_ctrl_t         ctrl_i,
  input  logic signed [VAL_W-1:0] value_i,
  input  logic [CNT_W-1:0]        count_i,
  output logic signed [VAL_W-1:0] head_o
);

  logic                    gt  [MAX_K];
  logic signed [VAL_W-1:0] val [MAX_K];

  for (genvar i = 0; i < MAX_K; i++) begin : g_cell
    logic                    occupied;
    logic                    prev_gt;
    logic signed [VAL_W-1:0] prev_val;
    logic signed [VAL_W-1:0] next_val;

    assign occupied = CNT_W'(i) < count_i;

    if (i == 0) begin : g_first
      assign prev_gt  = 1'b0;
      assign prev_val = value_i;
    end else begin : g_mid
      assign prev_gt  = gt[i-1];
      assign prev_val = val[i-1];
    end

    if (i == MAX_K - 1) begin : g_last
      assign next_val = val[i];
    end else begin : g_inner
      assign next_val = val[i+1];
    end

    kls_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl_i),
      .occupied_i (occupied),
      .value_i    (value_i),
      .prev_gt_i  (prev_gt),
      .prev_val_i (prev_val),
      .next_val_i (next_val),
      .gt_o       (gt[i]),
      .val_o      (val[i])
    );
  end

  assign head_o = val[0];

endmodule

// ===== sv/kth_largest_select.sv =====
// Top level: k-th largest selection over a streamed set of signed values.
//
// Values arrive on the input channel (value_i, last_i), one transfer per
// cycle while a set is loading; the last value of a set carries last_i.
// Each value is placed into a sorted row of MAX_K compare-insert cells in
// the cycle it is taken, so loading runs at one value per cycle.
// After the last transfer the row shifts toward its head k_rank - 1 times
// (not at all when the value is not found) and the head is registered as
// the result. Until then in_ready_o is low; it rises again once the result
// is registered, so the next set can load while the result waits.
// The output channel (kth_value_o, found_o) holds its result until the
// receiver takes it; a stalled receiver only delays the end of extraction.
// k_rank is written through the APB port at address 0; the user must write
// it only while idle, the block itself does not enforce this. Reset clears
// k_rank to 1, the fill count and the output valid; cell contents are not
// cleared and only filled cells are ever read.
module kth_largest_select import kls_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ADDR_W-1:0]       paddr,
  input  logic [DATA_W-1:0]       pwdata,
  output logic [DATA_W-1:0]       prdata,
  output logic                    pready,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [VAL_W-1:0] value_i,
  input  logic                    last_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [VAL_W-1:0] kth_value_o,
  output logic                    found_o
);

  kls_state_e state_q, state_d;
  logic [K_W-1:0]   k_rank_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             hit_q, hit_d;
  logic             out_valid_q, out_valid_d;
  logic signed [VAL_W-1:0] kth_q, kth_d;
  logic             found_q, found_d;

  logic             in_xfer;
  logic             cfg_wr;
  logic [CNT_W-1:0] count_ins;
  logic             hit;
  logic signed [VAL_W-1:0] head;
  kls_chain_ctrl_t  chain_ctrl;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[ADDR_W-1] == REG_K_RANK) ? DATA_W'(k_rank_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_rank_q <= K_RANK_RESET;
    end else if (cfg_wr && paddr[ADDR_W-1] == REG_K_RANK) begin
      k_rank_q <= pwdata[K_W-1:0];
    end
  end

  assign in_ready_o = (state_q == ST_LOAD);
  assign in_xfer    = in_valid_i && in_ready_o;

  assign count_ins = (count_q < CNT_W'(MAX_K)) ? count_q + CNT_W'(1) : count_q;
  assign hit = (k_rank_q != '0) &&
               (CMP_W'(k_rank_q) <= CMP_W'(MAX_K)) &&
               (CMP_W'(k_rank_q) <= CMP_W'(count_ins));

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    hit_d       = hit_q;
    out_valid_d = out_valid_q;
    kth_d       = kth_q;
    found_d     = found_q;
    chain_ctrl  = '{insert: in_xfer, shift: 1'b0};

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_LOAD: begin
        if (in_xfer) begin
          count_d = count_ins;
          if (last_i) begin
            count_d = '0;
            hit_d   = hit;
            idx_d   = hit ? IDX_W'(k_rank_q - K_W'(1)) : '0;
            state_d = ST_EXTRACT;
          end
        end
      end
      ST_EXTRACT: begin
        if (idx_q != '0) begin
          chain_ctrl.shift = 1'b1;
          idx_d = idx_q - IDX_W'(1);
        end else if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          kth_d       = hit_q ? head : '0;
          found_d     = hit_q;
          state_d     = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      count_q     <= '0;
      idx_q       <= '0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kth_q   <= kth_d;
    found_q <= found_d;
  end

  kls_chain u_chain (
    .clk_i   (clk_i),
    .ctrl_i  (chain_ctrl),
    .value_i (value_i),
    .count_i (count_q),
    .head_o  (head)
  );

  assign out_valid_o = out_valid_q;
  assign kth_value_o = kth_q;
  assign found_o     = found_q;

`ifndef SYNTHESIS
  a_last_stops_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && last_i |=> !in_ready_o && count_q == '0)
    else $error("input still taken after last transfer");

  a_miss_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> kth_value_o == '0)
    else $error("result without hit carries a nonzero value");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_K))
    else $error("fill count above capacity");

  a_no_shift_on_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(chain_ctrl.insert && chain_ctrl.shift))
    else $error("chain inserting and shifting at once");
`endif

endmodule

// ===== tb/tb_top.sv =====
// Testbench for kth_largest_select: streamed sets checked against a top-k predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import kls_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = MAX_K + 4;
  localparam int PHASE_ITEMS = 150;
  localparam logic [ADDR_W-1:0] K_RANK_ADDR = ADDR_W'(4 * REG_K_RANK);
  localparam logic [ADDR_W-1:0] SPARE_ADDR = ADDR_W'(4);
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    last;
  } set_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] kth;
    logic                    found;
  } kth_res_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [ADDR_W-1:0]       paddr = '0;
  logic [DATA_W-1:0]       pwdata = '0;
  logic [DATA_W-1:0]       prdata;
  logic                    pready;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic signed [VAL_W-1:0] value_i = '0;
  logic                    last_i = 1'b0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic signed [VAL_W-1:0] kth_value_o;
  logic                    found_o;

  set_item_t send_q[$];
  kth_res_t  kth_pending_q[$];

  logic signed [VAL_W-1:0] top_model[MAX_K];
  int                      fill_cnt = 0;
  logic [K_W-1:0]          k_cfg = K_RANK_RESET;

  logic in_taken = 1'b0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   mismatch_cnt = 0;
  int   items_sent = 0;
  int   cycle_cnt = 0;

  kth_largest_select u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .value_i    (value_i),
    .last_i     (last_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .kth_value_o(kth_value_o),
    .found_o    (found_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // sorted insert into the top-k store, smallest entry drops when full
  function automatic void rank_insert(input logic signed [VAL_W-1:0] v);
    int pos;
    int n;
    pos = 0;
    n = fill_cnt;
    while (pos < n && top_model[pos] >= v) pos++;
    if (pos >= MAX_K) return;
    if (n >= MAX_K) n = MAX_K - 1;
    while (n > pos) begin
      top_model[n] = top_model[n-1];
      n--;
    end
    top_model[pos] = v;
    if (fill_cnt < MAX_K) fill_cnt++;
  endfunction

  function automatic kth_res_t rank_result();
    kth_res_t r;
    int k;
    k = int'(k_cfg);
    r.kth = '0;
    r.found = 1'b0;
    if (k >= 1 && k <= MAX_K && k <= fill_cnt) begin
      r.kth = top_model[k-1];
      r.found = 1'b1;
    end
    fill_cnt = 0;
    return r;
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value(input int mode);
    int r;
    r = $urandom_range(0, 9);
    if (mode == 1 || (r >= 6 && r < 9)) return $signed($urandom_range(0, 8)) - 32'sd4;
    if (r < 6) return $signed($urandom());
    case ($urandom_range(0, 3))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2: return '0;
      default: return '1;
    endcase
  endfunction

  // input driver and output ready
  always @(negedge clk_i) begin : drive_proc
    set_item_t nxt;
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        if (send_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = send_q.pop_front();
          in_valid_i <= 1'b1;
          value_i <= nxt.value;
          last_i <= nxt.last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // predictor and result checker
  always @(posedge clk_i) begin : mon_proc
    kth_res_t want;
    if (rst_ni) begin
      in_taken <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) begin
        rank_insert(value_i);
        if (last_i) kth_pending_q.push_back(rank_result());
      end
      if (out_valid_o && out_ready_i) begin
        if (kth_pending_q.size() == 0) begin
          $display("%0t unexpected result: expected none, actual kth_value %0d found %0b",
                   $time, kth_value_o, found_o);
          mismatch_cnt++;
        end else begin
          want = kth_pending_q.pop_front();
          if (kth_value_o !== want.kth) begin
            $display("%0t kth_value mismatch: expected %0d, actual %0d",
                     $time, want.kth, kth_value_o);
            mismatch_cnt++;
          end
          if (found_o !== want.found) begin
            $display("%0t found mismatch: expected %0b, actual %0b",
                     $time, want.found, found_o);
            mismatch_cnt++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic push_item(input logic signed [VAL_W-1:0] v, input logic last);
    set_item_t it;
    it.value = v;
    it.last = last;
    send_q.push_back(it);
    items_sent++;
  endtask

  task automatic push_set(input int len, input int mode);
    int i;
    for (i = 0; i < len; i++) push_item(pick_value(mode), i == len - 1);
  endtask

  task automatic wait_results();
    while (send_q.size() != 0 || in_valid_i || kth_pending_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic settle();
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == K_RANK_ADDR) k_cfg = data[K_W-1:0];
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic apb_check_k();
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= K_RANK_ADDR;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[K_W-1:0] !== k_cfg) begin
      $display("%0t k_rank readback mismatch: expected %0d, actual %0d",
               $time, k_cfg, prdata[K_W-1:0]);
      mismatch_cnt++;
    end
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_k(input int k);
    settle();
    apb_write(K_RANK_ADDR, ($urandom() & ~32'h7F) | DATA_W'(k));
    apb_check_k();
  endtask

  initial begin : stim_proc
    int p;
    int start;
    int len;
    int r;
    bit paused;
    int k_plan[8];
    int idle_send[4];
    int idle_recv[4];
    k_plan = '{2, MAX_K, 0, 5, 127, 1, MAX_K + 1, 0};
    k_plan[7] = $urandom_range(1, 16);
    idle_send = '{0, 84, 0, 37};
    idle_recv = '{0, 0, 84, 37};

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset rank of one, extremes
    push_item(VAL_MIN, 1'b1);
    push_item(VAL_MAX, 1'b0);
    push_item('1, 1'b0);
    push_item('0, 1'b0);
    push_item(32'sd1, 1'b0);
    push_item(VAL_MIN, 1'b1);
    settle();
    apb_check_k();

    set_k(3);
    // too few values, then equal values
    push_item(32'sd7, 1'b0);
    push_item(32'sd7, 1'b1);
    push_item(32'sd5, 1'b0);
    push_item(32'sd9, 1'b0);
    push_item(32'sd5, 1'b0);
    push_item(32'sd5, 1'b1);
    push_item('1, 1'b0);
    push_item(VAL_MIN, 1'b0);
    push_item(-32'sd2, 1'b1);

    // write to an unused index leaves k_rank alone
    settle();
    apb_write(SPARE_ADDR, 32'h0000_0002);
    apb_check_k();
    push_item(32'sd1, 1'b0);
    push_item(32'sd2, 1'b0);
    push_item(32'sd3, 1'b1);

    // rank zero and rank past the store
    set_k(0);
    push_item(32'sd3, 1'b0);
    push_item(32'sd4, 1'b1);
    set_k(127);
    push_item(32'sd1, 1'b0);
    push_item(32'sd2, 1'b1);

    for (p = 0; p < 8; p++) begin
      set_k(k_plan[p]);
      send_idle_pct = idle_send[p % 4];
      recv_stall_pct = idle_recv[p % 4];
      start = items_sent;
      paused = 1'b0;
      while (items_sent - start < PHASE_ITEMS) begin
        if (!paused && items_sent - start >= PHASE_ITEMS / 2) begin
          wait_results();
          paused = 1'b1;
        end
        r = $urandom_range(0, 9);
        if (k_cfg == MAX_K) len = (r < 7) ? $urandom_range(60, 90) : $urandom_range(1, 10);
        else len = (r == 0) ? $urandom_range(60, 80) : $urandom_range(1, 12);
        push_set(len, ($urandom_range(0, 3) == 0) ? 1 : 0);
      end
    end

    settle();
    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
